>>> hw/rtl/prc_pkg.sv
// prc_pkg: types and constants shared by the receive ring classifier
// no dependencies
package prc_pkg;

  localparam int unsigned IN_BITS   = 128;
  localparam int unsigned OUT_BITS  = 160;
  localparam int unsigned CFG_BITS  = 23;
  localparam int unsigned WIN_BITS  = 11;
  localparam logic [WIN_BITS-1:0] WIN_CAP      = 11'd1024;
  localparam logic [WIN_BITS-1:0] POLL_MIN_RST = 11'd16;

  typedef enum logic [3:0] {
    ACT_NOTREADY = 4'd0,
    ACT_STALE    = 4'd1,
    ACT_CC       = 4'd2,
    ACT_COPY     = 4'd3,
    ACT_SHORT    = 4'd4,
    ACT_CCOFF    = 4'd5,
    ACT_CCLEN    = 4'd6,
    ACT_COPYLEN  = 4'd7,
    ACT_SHORTLEN = 4'd8
  } action_e;

  typedef enum logic [2:0] {
    CFG_COH_EN        = 3'd0,
    CFG_CC_PEER_READY = 3'd1,
    CFG_CC_BUF_BYTES  = 3'd2,
    CFG_COPY_SEG      = 3'd3,
    CFG_SHORT_MAX     = 3'd4,
    CFG_OWN_GEN       = 3'd5,
    CFG_POLL_MIN      = 3'd6,
    CFG_POLL_MAX      = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic        coh_enable;
    logic        cc_peer_ready;
    logic [22:0] cc_buffer_bytes;
    logic [15:0] copy_segment_bytes;
    logic [15:0] short_max_bytes;
    logic [15:0] own_generation;
  } cls_cfg_t;

  typedef struct packed {
    logic [63:0] header_word;
    logic [5:0]  message_id;
    logic [31:0] payload_length;
    logic [15:0] entry_generation;
    logic        copy_bit;
    logic        cc_bit;
    logic        owner_bit;
  } entry_t;

  typedef struct packed {
    logic                round_done;
    logic                publish_tail;
    logic [WIN_BITS-1:0] window_next;
  } round_t;

endpackage

>>> hw/rtl/prc_classify.sv
// prc_classify: readiness check and entry classification
// depends on prc_pkg
module prc_classify #(
  parameter int unsigned RING_DEPTH      = 128,
  parameter int unsigned MIN_SHORT_BYTES = 8
) (
  input  prc_pkg::entry_t   entry_i,
  input  prc_pkg::cls_cfg_t cfg_i,
  input  logic [31:0]       read_pos_i,
  output logic              ready_o,
  output prc_pkg::action_e  action_o,
  output logic [6:0]        slot_o
);
  import prc_pkg::*;

  logic phase;
  logic [31:0] masked;

  assign phase   = |(read_pos_i & 32'(RING_DEPTH));
  assign masked  = read_pos_i & 32'(RING_DEPTH - 1);
  assign slot_o  = masked[6:0];
  assign ready_o = entry_i.owner_bit != phase;

  always_comb begin
    if (!ready_o) begin
      action_o = ACT_NOTREADY;
    end else if (entry_i.entry_generation != cfg_i.own_generation) begin
      action_o = ACT_STALE;
    end else if (entry_i.cc_bit) begin
      if (!cfg_i.coh_enable || !cfg_i.cc_peer_ready) begin
        action_o = ACT_CCOFF;
      end else if (entry_i.payload_length > {9'd0, cfg_i.cc_buffer_bytes}) begin
        action_o = ACT_CCLEN;
      end else begin
        action_o = ACT_CC;
      end
    end else if (entry_i.copy_bit) begin
      if (entry_i.payload_length > {16'd0, cfg_i.copy_segment_bytes}) begin
        action_o = ACT_COPYLEN;
      end else begin
        action_o = ACT_COPY;
      end
    end else if (entry_i.payload_length < 32'(MIN_SHORT_BYTES) ||
                 entry_i.payload_length > {16'd0, cfg_i.short_max_bytes}) begin
      action_o = ACT_SHORTLEN;
    end else begin
      action_o = ACT_SHORT;
    end
  end

endmodule

>>> hw/rtl/prc_ring.sv
// prc_ring: read position, round count and adaptive poll window
// depends on prc_pkg
module prc_ring #(
  parameter int unsigned SHRINK_DIVISOR = 2,
  parameter int unsigned GROW_STEP      = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic                         entry_ready_i,
  input  logic [prc_pkg::WIN_BITS-1:0] poll_min_i,
  input  logic [prc_pkg::WIN_BITS-1:0] poll_max_i,
  input  logic                         reload_i,
  input  logic [prc_pkg::WIN_BITS-1:0] reload_value_i,
  output logic [31:0]                  read_pos_o,
  output prc_pkg::round_t              round_o
);
  import prc_pkg::*;

  // window / SHRINK_DIVISOR as a multiply by a rounded-up reciprocal
  localparam int unsigned SHR_L = $clog2(SHRINK_DIVISOR);
  localparam int unsigned SHR_S = WIN_BITS + SHR_L;
  localparam int unsigned SHR_M = ((1 << SHR_S) + SHRINK_DIVISOR - 1) / SHRINK_DIVISOR;

  logic [31:0]         read_pos_q, read_pos_d;
  logic [WIN_BITS-1:0] count_q, count_d;
  logic [WIN_BITS-1:0] window_q, window_d;
  logic                full_q, full_d;

  logic [WIN_BITS-1:0] count_inc, consumed, shrunk;
  logic [31:0]         shr_prod;
  logic [WIN_BITS:0]   grown, wsel;
  logic [WIN_BITS-1:0] wclamp;
  logic                adj_full;
  logic                done;

  function automatic logic [WIN_BITS-1:0] clamp_win(input logic [WIN_BITS:0] w);
    if (w == '0) begin
      return WIN_BITS'(1);
    end else if (w > {1'b0, WIN_CAP}) begin
      return WIN_CAP;
    end else begin
      return w[WIN_BITS-1:0];
    end
  endfunction

  assign count_inc = (count_q < WIN_CAP) ? count_q + WIN_BITS'(1) : count_q;
  assign consumed  = entry_ready_i ? count_inc : count_q;
  assign done      = !entry_ready_i || (count_inc >= window_q);
  assign shr_prod  = 32'(window_q) * 32'(SHR_M);
  assign shrunk    = WIN_BITS'(shr_prod >> SHR_S);
  assign grown     = {1'b0, window_q} + (WIN_BITS + 1)'(GROW_STEP);

  always_comb begin
    adj_full = full_q;
    if (consumed < window_q) begin
      wsel     = (shrunk > poll_min_i) ? {1'b0, shrunk} : {1'b0, poll_min_i};
      adj_full = 1'b0;
    end else if (full_q) begin
      wsel = (grown < {1'b0, poll_max_i}) ? grown : {1'b0, poll_max_i};
    end else begin
      wsel     = {1'b0, window_q};
      adj_full = 1'b1;
    end
  end

  assign wclamp = clamp_win(wsel);

  always_comb begin
    read_pos_d = read_pos_q;
    count_d    = count_q;
    window_d   = window_q;
    full_d     = full_q;
    if (reload_i) begin
      window_d = clamp_win({1'b0, reload_value_i});
    end else if (step_i) begin
      read_pos_d = read_pos_q + {31'd0, entry_ready_i};
      if (done) begin
        count_d  = '0;
        window_d = wclamp;
        full_d   = adj_full;
      end else begin
        count_d = consumed;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_pos_q <= '0;
      count_q    <= '0;
      window_q   <= POLL_MIN_RST;
      full_q     <= 1'b0;
    end else begin
      read_pos_q <= read_pos_d;
      count_q    <= count_d;
      window_q   <= window_d;
      full_q     <= full_d;
    end
  end

  assign read_pos_o           = read_pos_q;
  assign round_o.round_done   = done;
  assign round_o.publish_tail = entry_ready_i ? done : (count_q != '0);
  assign round_o.window_next  = done ? wclamp : window_q;

endmodule

>>> hw/rtl/phase_bit_ring_receive_classifier.sv
// phase_bit_ring_receive_classifier: top level, stream ports and configuration
// depends on prc_pkg, prc_classify, prc_ring
//
// Takes one ring entry header per word and returns one result word per entry.
// An entry is registered on entry, then classified and applied to the ring state
// as its result is captured in an output register, so one entry is taken every
// cycle while the output side does not stall; read position, round count and
// poll window are updated in a single step, which sets that rate. A stall on the
// output side holds the input register and backs up through s_axis_tready.
// Configuration writes take effect at the edge they are presented and must only
// be made while no entry is in flight; writing poll_min also reloads the window.
module phase_bit_ring_receive_classifier #(
  parameter int unsigned RING_DEPTH      = 128,
  parameter int unsigned SHRINK_DIVISOR  = 2,
  parameter int unsigned GROW_STEP       = 1,
  parameter int unsigned MIN_SHORT_BYTES = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [2:0]                     cfg_idx_i,
  input  logic [prc_pkg::CFG_BITS-1:0]   cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // owner_bit, cc_bit, copy_bit, entry_generation, payload_length, message_id,
  // header_word
  input  logic [prc_pkg::IN_BITS-1:0]    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // slot, handler_id, deliver_length, coherent offset, publish_tail, tail_index,
  // window_next
  output logic [prc_pkg::OUT_BITS-1:0]   m_axis_tdata,
  // action
  output logic [3:0]                     m_axis_tuser,
  // round_done
  output logic                           m_axis_tlast
);
  import prc_pkg::*;

  cls_cfg_t            cfg_q;
  logic [WIN_BITS-1:0] poll_min_q, poll_max_q;

  logic   in_valid_q;
  entry_t in_q;
  logic   step;

  logic        ready;
  action_e     action;
  logic [6:0]  slot;
  logic [31:0] read_pos, tail;
  round_t      round;
  logic        reload;

  logic                out_valid_q;
  action_e             action_q;
  logic [6:0]          slot_q;
  logic [5:0]          hid_q;
  logic [31:0]         dlen_q;
  logic [63:0]         ccoff_q;
  logic                done_q, pub_q;
  logic [31:0]         tail_q;
  logic [WIN_BITS-1:0] win_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coh_enable         <= 1'b0;
      cfg_q.cc_peer_ready      <= 1'b0;
      cfg_q.cc_buffer_bytes    <= 23'd2097152;
      cfg_q.copy_segment_bytes <= 16'd19776;
      cfg_q.short_max_bytes    <= 16'd2048;
      cfg_q.own_generation     <= 16'd0;
      poll_min_q               <= POLL_MIN_RST;
      poll_max_q               <= POLL_MIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_COH_EN:        cfg_q.coh_enable         <= cfg_data_i[0];
        CFG_CC_PEER_READY: cfg_q.cc_peer_ready      <= cfg_data_i[0];
        CFG_CC_BUF_BYTES:  cfg_q.cc_buffer_bytes    <= cfg_data_i;
        CFG_COPY_SEG:      cfg_q.copy_segment_bytes <= cfg_data_i[15:0];
        CFG_SHORT_MAX:     cfg_q.short_max_bytes    <= cfg_data_i[15:0];
        CFG_OWN_GEN:       cfg_q.own_generation     <= cfg_data_i[15:0];
        CFG_POLL_MIN:      poll_min_q               <= cfg_data_i[WIN_BITS-1:0];
        CFG_POLL_MAX:      poll_max_q               <= cfg_data_i[WIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign reload = cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CFG_POLL_MIN);

  // input register
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q <= entry_t'(s_axis_tdata[120:0]);
    end
  end

  prc_classify #(
    .RING_DEPTH      (RING_DEPTH),
    .MIN_SHORT_BYTES (MIN_SHORT_BYTES)
  ) u_classify (
    .entry_i    (in_q),
    .cfg_i      (cfg_q),
    .read_pos_i (read_pos),
    .ready_o    (ready),
    .action_o   (action),
    .slot_o     (slot)
  );

  prc_ring #(
    .SHRINK_DIVISOR (SHRINK_DIVISOR),
    .GROW_STEP      (GROW_STEP)
  ) u_ring (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .entry_ready_i  (ready),
    .poll_min_i     (poll_min_q),
    .poll_max_i     (poll_max_q),
    .reload_i       (reload),
    .reload_value_i (cfg_data_i[WIN_BITS-1:0]),
    .read_pos_o     (read_pos),
    .round_o        (round)
  );

  assign tail = read_pos + {31'd0, ready};

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      action_q <= action;
      slot_q   <= slot;
      hid_q    <= ready ? in_q.message_id : 6'd0;
      dlen_q   <= ready ? in_q.payload_length : 32'd0;
      ccoff_q  <= (action == ACT_CC) ? in_q.header_word : 64'd0;
      done_q   <= round.round_done;
      pub_q    <= round.publish_tail;
      tail_q   <= tail;
      win_q    <= round.window_next;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = action_q;
  assign m_axis_tlast  = done_q;
  assign m_axis_tdata  = {7'd0, win_q, tail_q, pub_q, ccoff_q, dlen_q, hid_q, slot_q};

`ifndef SYNTHESIS
  a_publish_ends_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && round.publish_tail |-> round.round_done)
    else $error("tail published without end of round");

  a_notready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (action_q == ACT_NOTREADY) |-> (dlen_q == '0) && (hid_q == '0) && done_q)
    else $error("not-ready result carries payload or keeps round open");

  a_window_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (win_q != '0) && (win_q <= WIN_CAP))
    else $error("poll window out of range");

  a_pos_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> read_pos == $past(read_pos))
    else $error("read position moved without an entry");
`endif

endmodule
